>>> rtl/assert_macros.svh
// Assertion helpers for the ellipse vertex generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, disabled while the active-low reset is asserted.
`define EVG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block's own clock and reset.
`define EVG_ASSERT(label, prop, msg) \
    `EVG_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

>>> rtl/evg_pkg.sv
`default_nettype none

package evg_pkg;

    // Field widths
    localparam int AXIS_W     = 12;
    localparam int VCOUNT_W   = 13;
    localparam int COORD_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MAJOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEMI_MINOR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd2;

    // Quadrant codes (top two bits of the turn angle)
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // CORDIC datapath: Q30 vector with headroom, 32-bit turn angle
    localparam int VEC_W        = 33;
    localparam int ANG_W        = 32;
    localparam int RESID_W      = 30;
    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 33'sd652032874;

    // Scaling: axis * v / 2^26, rounded, saturated
    localparam int PROD_W      = AXIS_W + 1 + VEC_W;
    localparam int ROUND_SHIFT = 26;
    localparam int QMAG_W      = PROD_W + 1 - ROUND_SHIFT;
    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (ROUND_SHIFT - 1);
    localparam logic [QMAG_W-1:0] COORD_POS_LIMIT = QMAG_W'(65535);
    localparam logic [QMAG_W-1:0] COORD_NEG_LIMIT = QMAG_W'(65536);

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [ANG_W-1:0] t_ang;

    // Arctangent of 2^-k in units of 2^-32 turn
    function automatic t_ang atan_turn(input int unsigned k);
        t_ang v;
        case (k)
            0:       v = 32'sd536870912;
            1:       v = 32'sd316933406;
            2:       v = 32'sd167458907;
            3:       v = 32'sd85004756;
            4:       v = 32'sd42667331;
            5:       v = 32'sd21354465;
            6:       v = 32'sd10679838;
            7:       v = 32'sd5340245;
            8:       v = 32'sd2670163;
            9:       v = 32'sd1335087;
            10:      v = 32'sd667544;
            11:      v = 32'sd333772;
            12:      v = 32'sd166886;
            13:      v = 32'sd83443;
            14:      v = 32'sd41722;
            15:      v = 32'sd20861;
            16:      v = 32'sd10430;
            17:      v = 32'sd5215;
            18:      v = 32'sd2608;
            19:      v = 32'sd1304;
            20:      v = 32'sd652;
            21:      v = 32'sd326;
            22:      v = 32'sd163;
            23:      v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ellipse_vertex_generator.sv
`default_nettype none
// Channel   Direction  Handshake              Payload
// input     in         i_in_valid/o_in_stall   i_vertex_index
// output    out        o_out_valid/i_out_stall o_x_coord, o_y_coord, o_out_of_range
// config    in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One vertex per clock while the output is not stalled. The pipeline is
// the input register, the long divider (one quotient bit a stage), the
// CORDIC (one rotation a stage), then fold, scale, round and output.
// Reset is synchronous, active low: pipeline valids clear, registers go
// to semi axes 0 and vertex count 1. A stall on the output freezes every
// stage at once; nothing is lost or repeated.

`include "assert_macros.svh"

module ellipse_vertex_generator
    import evg_pkg::*;
#(
    parameter int MAX_VERTICES  = 4096,
    parameter int CORDIC_STAGES = 16,
    parameter int PHASE_BITS    = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire [VCOUNT_W-1:0]          i_vertex_index,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic signed [COORD_W-1:0]   o_x_coord,
    output logic signed [COORD_W-1:0]   o_y_coord,
    output logic                        o_out_of_range,
    input  wire                         i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire [CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int LAST_DV = PHASE_BITS - 1;
    localparam int LAST_CD = CORDIC_STAGES - 1;

    // ------------------------------------------------------------------
    // Configuration registers; the vertex count is stored already clamped
    // ------------------------------------------------------------------
    logic [AXIS_W-1:0]   r_semi_major;
    logic [AXIS_W-1:0]   r_semi_minor;
    logic [VCOUNT_W-1:0] r_count;
    logic [VCOUNT_W-1:0] n_count;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_count = VCOUNT_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_VERTICES)) begin
            n_count = VCOUNT_W'(MAX_VERTICES);
        end else begin
            n_count = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_semi_major <= '0;
            r_semi_minor <= '0;
            r_count      <= VCOUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SEMI_MAJOR:   r_semi_major <= i_cfg_data[AXIS_W-1:0];
                REG_SEMI_MINOR:   r_semi_minor <= i_cfg_data[AXIS_W-1:0];
                REG_VERTEX_COUNT: r_count      <= n_count;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: the whole pipe holds while the output beat waits
    // ------------------------------------------------------------------
    logic w_adv;
    logic r_out_valid;

    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    // ------------------------------------------------------------------
    // Input stage: range checks
    // ------------------------------------------------------------------
    logic                r_in_valid;
    logic                r_in_oor;
    logic                r_in_wrap;
    logic [VCOUNT_W-1:0] r_in_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_oor   <= i_vertex_index > r_count;
            r_in_wrap  <= i_vertex_index == r_count;
            r_in_index <= i_vertex_index;
        end
    end

    // ------------------------------------------------------------------
    // Long division: phase = floor(index * 2^PHASE_BITS / count),
    // one quotient bit per stage. For in-range beats index < count, so the
    // quotient fits; the closing index is forced to phase zero afterward.
    // ------------------------------------------------------------------
    logic                  r_dv_valid [PHASE_BITS];
    logic                  r_dv_oor   [PHASE_BITS];
    logic                  r_dv_wrap  [PHASE_BITS];
    logic [VCOUNT_W-1:0]   r_dv_rem   [PHASE_BITS];
    logic [PHASE_BITS-1:0] r_dv_quo   [PHASE_BITS];

    for (genvar j = 0; j < PHASE_BITS; j++) begin : g_div
        logic                  w_vi;
        logic                  w_oi;
        logic                  w_wi;
        logic [VCOUNT_W-1:0]   w_ri;
        logic [PHASE_BITS-1:0] w_qi;
        logic [VCOUNT_W:0]     w_rem2;
        logic [VCOUNT_W:0]     w_diff;
        logic                  w_ge;

        if (j == 0) begin : g_first
            assign w_vi = r_in_valid;
            assign w_oi = r_in_oor;
            assign w_wi = r_in_wrap;
            assign w_ri = r_in_index;
            assign w_qi = '0;
        end else begin : g_next
            assign w_vi = r_dv_valid[j-1];
            assign w_oi = r_dv_oor[j-1];
            assign w_wi = r_dv_wrap[j-1];
            assign w_ri = r_dv_rem[j-1];
            assign w_qi = r_dv_quo[j-1];
        end

        assign w_rem2 = {w_ri, 1'b0};
        assign w_ge   = w_rem2 >= {1'b0, r_count};
        assign w_diff = w_rem2 - {1'b0, r_count};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[j] <= 1'b0;
            end else if (w_adv) begin
                r_dv_valid[j] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv_oor[j]  <= w_oi;
                r_dv_wrap[j] <= w_wi;
                r_dv_rem[j]  <= w_ge ? w_diff[VCOUNT_W-1:0] : w_rem2[VCOUNT_W-1:0];
                r_dv_quo[j]  <= {w_qi[PHASE_BITS-2:0], w_ge};
            end
        end
    end

    // Turn angle: phase in the top bits of a 32-bit turn
    logic [PHASE_BITS-1:0] w_phase;
    logic [ANG_W-1:0]      w_turn;

    assign w_phase = r_dv_wrap[LAST_DV] ? '0 : r_dv_quo[LAST_DV];
    assign w_turn  = ANG_W'(w_phase) << (ANG_W - PHASE_BITS);

    // ------------------------------------------------------------------
    // CORDIC rotation of (K, 0) by the residual below a quarter turn
    // ------------------------------------------------------------------
    logic       r_cd_valid [CORDIC_STAGES];
    logic       r_cd_oor   [CORDIC_STAGES];
    logic [1:0] r_cd_quad  [CORDIC_STAGES];
    t_vec       r_cd_x     [CORDIC_STAGES];
    t_vec       r_cd_y     [CORDIC_STAGES];
    t_ang       r_cd_z     [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        logic       w_vi;
        logic       w_oi;
        logic [1:0] w_qi;
        t_vec       w_xi;
        t_vec       w_yi;
        t_ang       w_zi;
        t_vec       w_dx;
        t_vec       w_dy;
        t_ang       w_atan;

        if (k == 0) begin : g_first
            assign w_vi = r_dv_valid[LAST_DV];
            assign w_oi = r_dv_oor[LAST_DV];
            assign w_qi = w_turn[ANG_W-1 -: 2];
            assign w_xi = CORDIC_GAIN;
            assign w_yi = '0;
            assign w_zi = t_ang'({2'b00, w_turn[RESID_W-1:0]});
        end else begin : g_next
            assign w_vi = r_cd_valid[k-1];
            assign w_oi = r_cd_oor[k-1];
            assign w_qi = r_cd_quad[k-1];
            assign w_xi = r_cd_x[k-1];
            assign w_yi = r_cd_y[k-1];
            assign w_zi = r_cd_z[k-1];
        end

        assign w_dx   = w_yi >>> k;
        assign w_dy   = w_xi >>> k;
        assign w_atan = atan_turn(k);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cd_valid[k] <= 1'b0;
            end else if (w_adv) begin
                r_cd_valid[k] <= w_vi;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_cd_oor[k]  <= w_oi;
                r_cd_quad[k] <= w_qi;
                if (!w_zi[ANG_W-1]) begin
                    r_cd_x[k] <= w_xi - w_dx;
                    r_cd_y[k] <= w_yi + w_dy;
                    r_cd_z[k] <= w_zi - w_atan;
                end else begin
                    r_cd_x[k] <= w_xi + w_dx;
                    r_cd_y[k] <= w_yi - w_dy;
                    r_cd_z[k] <= w_zi + w_atan;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Quadrant fold
    // ------------------------------------------------------------------
    logic r_qm_valid;
    logic r_qm_oor;
    t_vec r_qm_cx;
    t_vec r_qm_sy;
    t_vec w_cx;
    t_vec w_sy;

    always_comb begin
        case (r_cd_quad[LAST_CD])
            QUAD_0: begin
                w_cx = r_cd_x[LAST_CD];
                w_sy = r_cd_y[LAST_CD];
            end
            QUAD_1: begin
                w_cx = -r_cd_y[LAST_CD];
                w_sy = r_cd_x[LAST_CD];
            end
            QUAD_2: begin
                w_cx = -r_cd_x[LAST_CD];
                w_sy = -r_cd_y[LAST_CD];
            end
            default: begin
                w_cx = r_cd_y[LAST_CD];
                w_sy = -r_cd_x[LAST_CD];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qm_valid <= 1'b0;
        end else if (w_adv) begin
            r_qm_valid <= r_cd_valid[LAST_CD];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_qm_oor <= r_cd_oor[LAST_CD];
            r_qm_cx  <= w_cx;
            r_qm_sy  <= w_sy;
        end
    end

    // ------------------------------------------------------------------
    // Scale by the semi axes
    // ------------------------------------------------------------------
    logic                     r_ml_valid;
    logic                     r_ml_oor;
    logic signed [PROD_W-1:0] r_ml_px;
    logic signed [PROD_W-1:0] r_ml_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml_valid <= 1'b0;
        end else if (w_adv) begin
            r_ml_valid <= r_qm_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ml_oor <= r_qm_oor;
            r_ml_px  <= $signed({1'b0, r_semi_major}) * r_qm_cx;
            r_ml_py  <= $signed({1'b0, r_semi_minor}) * r_qm_sy;
        end
    end

    // ------------------------------------------------------------------
    // Round magnitude half away from zero
    // ------------------------------------------------------------------
    logic              r_rd_valid;
    logic              r_rd_oor;
    logic              r_rd_xneg;
    logic              r_rd_yneg;
    logic [QMAG_W-1:0] r_rd_xmag;
    logic [QMAG_W-1:0] r_rd_ymag;
    logic [PROD_W:0]   w_xsum;
    logic [PROD_W:0]   w_ysum;

    assign w_xsum = {1'b0, (r_ml_px[PROD_W-1] ? -r_ml_px : r_ml_px)} + ROUND_HALF;
    assign w_ysum = {1'b0, (r_ml_py[PROD_W-1] ? -r_ml_py : r_ml_py)} + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (w_adv) begin
            r_rd_valid <= r_ml_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_oor  <= r_ml_oor;
            r_rd_xneg <= r_ml_px[PROD_W-1];
            r_rd_yneg <= r_ml_py[PROD_W-1];
            r_rd_xmag <= w_xsum[PROD_W -: QMAG_W];
            r_rd_ymag <= w_ysum[PROD_W -: QMAG_W];
        end
    end

    // ------------------------------------------------------------------
    // Sign, saturate, output register
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic                      r_out_oor;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic              neg,
        input logic [QMAG_W-1:0] mag
    );
        logic signed [QMAG_W:0] sv;
        logic signed [COORD_W-1:0] res;
        sv = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (!neg && mag > COORD_POS_LIMIT) begin
            res = COORD_W'(COORD_POS_LIMIT);
        end else if (neg && mag > COORD_NEG_LIMIT) begin
            res = -COORD_W'(COORD_NEG_LIMIT);
        end else begin
            res = sv[COORD_W-1:0];
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_rd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_oor <= r_rd_oor;
            r_out_x   <= r_rd_oor ? '0 : sat_coord(r_rd_xneg, r_rd_xmag);
            r_out_y   <= r_rd_oor ? '0 : sat_coord(r_rd_yneg, r_rd_ymag);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_x_coord      = r_out_x;
    assign o_y_coord      = r_out_y;
    assign o_out_of_range = r_out_oor;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `EVG_ASSERT(a_count_clamped, (r_count != '0) && (32'(r_count) <= 32'(MAX_VERTICES)), "vertex count register outside 1..MAX_VERTICES")

    `EVG_ASSERT(a_div_rem_below_count, r_dv_valid[LAST_DV] && !r_dv_oor[LAST_DV] && !r_dv_wrap[LAST_DV] |-> r_dv_rem[LAST_DV] < r_count, "divider remainder not below vertex count")

    `EVG_ASSERT(a_oor_zero_coords, r_out_valid && r_out_oor |-> (r_out_x == '0) && (r_out_y == '0), "out-of-range beat carries nonzero coordinates")

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import evg_pkg::*;

    localparam int MAX_VERTICES   = 4096;
    localparam int CORDIC_STAGES  = 16;
    localparam int PHASE_BITS     = 16;
    localparam int LATENCY        = PHASE_BITS + CORDIC_STAGES + 5;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SWEEP_SETTINGS = 10;
    localparam int SWEEP_BEATS    = 120;

    // No register lives at this index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Arctangent of 2^-k, units of 2^-32 turn
    localparam longint ATAN_TURN [CORDIC_STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      off_strip;
    } vertex_t;

    typedef enum logic {RX_FREE, RX_CHOPPY} rx_mode_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [VCOUNT_W-1:0]        i_vertex_index = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [COORD_W-1:0]  o_x_coord;
    logic signed [COORD_W-1:0]  o_y_coord;
    logic                       o_out_of_range;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = REG_SEMI_MAJOR;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // Shadow copy of the configuration registers
    logic [AXIS_W-1:0]   cfg_major = '0;
    logic [AXIS_W-1:0]   cfg_minor = '0;
    logic [VCOUNT_W-1:0] cfg_count = VCOUNT_W'(1);

    vertex_t  pending_vertices[$];
    int       err_count = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    bit       tx_gaps = 1'b0;
    rx_mode_t rx_mode = RX_FREE;
    bit       hold_req = 1'b0;
    int       hold_left = 0;
    int       run_left = 0;
    bit       stall_run = 1'b0;

    ellipse_vertex_generator #(
        .MAX_VERTICES  (MAX_VERTICES),
        .CORDIC_STAGES (CORDIC_STAGES),
        .PHASE_BITS    (PHASE_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_vertex_index (i_vertex_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_x_coord      (o_x_coord),
        .o_y_coord      (o_y_coord),
        .o_out_of_range (o_out_of_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Vertex count as the block uses it: zero reads as one, clamp at the max
    function automatic int active_count();
        int n;
        n = cfg_count;
        if (n == 0) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        return n;
    endfunction

    // axis * v / 2^26, round half away from zero, saturate to Q13.4
    function automatic logic signed [COORD_W-1:0] scale_axis(
        input logic [AXIS_W-1:0] axis, input longint v);
        longint p, mag, q;
        p   = longint'(axis) * v;
        mag = (p < 0) ? -p : p;
        q   = (mag + 64'sd33554432) >>> 26;
        if (p < 0) q = -q;
        if (q > 65535) q = 65535;
        if (q < -65536) q = -65536;
        return q[COORD_W-1:0];
    endfunction

    function automatic vertex_t predict_vertex(input logic [VCOUNT_W-1:0] idx);
        vertex_t                 r;
        longint                  n, x, y, z, dx, dy, cx, sy;
        logic [PHASE_BITS-1:0]   phase;
        logic [1:0]              quad;
        n = active_count();
        if (longint'(idx) > n) begin
            r.x         = '0;
            r.y         = '0;
            r.off_strip = 1'b1;
            return r;
        end
        // index == count wraps to phase zero
        phase = PHASE_BITS'((longint'(idx) << PHASE_BITS) / n);
        quad  = phase[PHASE_BITS-1 -: 2];
        x = CORDIC_GAIN;
        y = 0;
        z = longint'({phase[PHASE_BITS-3:0], {(ANG_W-PHASE_BITS){1'b0}}});
        for (int k = 0; k < CORDIC_STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURN[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURN[k];
            end
        end
        case (quad)
            QUAD_0: begin cx = x;  sy = y;  end
            QUAD_1: begin cx = -y; sy = x;  end
            QUAD_2: begin cx = -x; sy = -y; end
            default: begin cx = y; sy = -x; end
        endcase
        r.x         = scale_axis(cfg_major, cx);
        r.y         = scale_axis(cfg_minor, sy);
        r.off_strip = 1'b0;
        return r;
    endfunction

    // Check each output beat against the oldest prediction
    always @(posedge i_clk) begin
        vertex_t exp_v;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_vertices.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d oor=%0b", $time,
                         o_x_coord, o_y_coord, o_out_of_range);
                err_count++;
            end else begin
                exp_v = pending_vertices.pop_front();
                if (o_x_coord !== exp_v.x) begin
                    $display("%0t: x_coord expected %0d got %0d", $time, exp_v.x, o_x_coord);
                    err_count++;
                end
                if (o_y_coord !== exp_v.y) begin
                    $display("%0t: y_coord expected %0d got %0d", $time, exp_v.y, o_y_coord);
                    err_count++;
                end
                if (o_out_of_range !== exp_v.off_strip) begin
                    $display("%0t: out_of_range expected %0b got %0b", $time,
                             exp_v.off_strip, o_out_of_range);
                    err_count++;
                end
            end
        end
    end

    // Output stall pattern; a requested hold-off is counted here
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (hold_req) begin
            hold_req    = 1'b0;
            hold_left   = HOLD_CYCLES - 1;
            i_out_stall = 1'b1;
        end else if (rx_mode == RX_FREE) begin
            i_out_stall = 1'b0;
        end else begin
            if (run_left == 0) begin
                stall_run = ($urandom_range(0, 2) == 0);
                run_left  = $urandom_range(1, 10);
            end
            run_left--;
            i_out_stall = stall_run;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one index; hold it until accepted, then maybe open a gap
    task automatic send_vertex(input logic [VCOUNT_W-1:0] idx);
        int gap;
        i_in_valid     = 1'b1;
        i_vertex_index = idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_vertices.push_back(predict_vertex(idx));
        @(negedge i_clk);
        if (tx_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap        = $urandom_range(1, 8);
                i_in_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_vertices.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SEMI_MAJOR:   cfg_major = data[AXIS_W-1:0];
            REG_SEMI_MINOR:   cfg_minor = data[AXIS_W-1:0];
            REG_VERTEX_COUNT: cfg_count = data[VCOUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_ellipse(input logic [CFG_DATA_W-1:0] major,
                               input logic [CFG_DATA_W-1:0] minor,
                               input logic [CFG_DATA_W-1:0] count);
        write_reg(REG_SEMI_MAJOR, major);
        write_reg(REG_SEMI_MINOR, minor);
        write_reg(REG_VERTEX_COUNT, count);
    endtask

    // Mostly strip walks, some single points, some past the end, some noise
    task automatic send_random_vertices(input int count);
        int sent, n, first, len, pick;
        sent = 0;
        n    = active_count();
        while (sent < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                len   = $urandom_range(1, 40);
                first = $urandom_range(0, n);
                for (int i = first; i <= n && i < first + len; i++) begin
                    send_vertex(VCOUNT_W'(i));
                    sent++;
                end
            end else if (pick < 8) begin
                send_vertex(VCOUNT_W'($urandom_range(0, n)));
                sent++;
            end else if (pick == 8) begin
                send_vertex(VCOUNT_W'(n + $urandom_range(1, 8)));
                sent++;
            end else begin
                send_vertex(VCOUNT_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_reset_state();
        send_vertex(VCOUNT_W'(0));
        send_vertex(VCOUNT_W'(1));
        send_vertex(VCOUNT_W'(2));
        send_vertex({VCOUNT_W{1'b1}});
        wait_drained();
    endtask

    task automatic test_directed_corners();
        // Quarter turns, the closing vertex and indexes past the end
        set_ellipse(13'd4095, 13'd4095, 13'd4);
        for (int i = 0; i <= 4; i++) send_vertex(VCOUNT_W'(i));
        send_vertex(VCOUNT_W'(5));
        send_vertex(VCOUNT_W'(4096));
        send_vertex({VCOUNT_W{1'b1}});
        wait_drained();
        // Top data bit drops on the axes; a zero count acts as one
        set_ellipse(13'h1FFF, 13'h1000, 13'd0);
        write_reg(REG_SPARE, 13'h1555);
        send_vertex(VCOUNT_W'(0));
        send_vertex(VCOUNT_W'(1));
        send_vertex(VCOUNT_W'(2));
        wait_drained();
        // Count above the max clamps to it
        set_ellipse(13'd1, 13'd4095, 13'h1FFF);
        send_vertex(VCOUNT_W'(4096));
        send_vertex(VCOUNT_W'(4097));
        send_vertex(VCOUNT_W'(1024));
        send_vertex(VCOUNT_W'(2048));
        send_vertex(VCOUNT_W'(3072));
        send_vertex(VCOUNT_W'(4095));
        send_vertex(VCOUNT_W'(1));
        send_vertex(VCOUNT_W'(0));
        wait_drained();
    endtask

    task automatic test_random_sweep();
        logic [CFG_DATA_W-1:0] count;
        for (int s = 0; s < SWEEP_SETTINGS; s++) begin
            case ($urandom_range(0, 5))
                0: count = CFG_DATA_W'($urandom_range(1, 16));
                1: count = CFG_DATA_W'($urandom_range(17, 200));
                2: count = CFG_DATA_W'(MAX_VERTICES);
                3: count = CFG_DATA_W'($urandom_range(MAX_VERTICES + 1, 8191));
                4: count = '0;
                default: count = CFG_DATA_W'($urandom_range(1, MAX_VERTICES));
            endcase
            if (s == 0)
                set_ellipse(13'd0, 13'd4095, 13'd1);
            else if (s == 1)
                set_ellipse(13'd4095, 13'd0, CFG_DATA_W'(MAX_VERTICES));
            else
                set_ellipse(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), count);
            // first settings run with no idling on either side
            tx_gaps = (s >= 2) && ($urandom_range(0, 3) != 0);
            rx_mode = ((s >= 2) && ($urandom_range(0, 3) != 0)) ? RX_CHOPPY : RX_FREE;
            send_random_vertices(SWEEP_BEATS);
            wait_drained();
        end
    endtask

    task automatic test_output_holdoff();
        set_ellipse(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                    CFG_DATA_W'($urandom_range(3, 300)));
        tx_gaps  = 1'b0;
        rx_mode  = RX_CHOPPY;
        hold_req = 1'b1;
        send_random_vertices(150);
        wait_drained();
    endtask

    task automatic test_pause_to_empty();
        tx_gaps = 1'b1;
        rx_mode = RX_CHOPPY;
        send_random_vertices(40);
        wait_drained();
        send_random_vertices(40);
        wait_drained();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed_corners();
        test_random_sweep();
        test_output_holdoff();
        test_pause_to_empty();

        rx_mode = RX_FREE;
        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);
        if (pending_vertices.size() != 0) begin
            $display("%0t: %0d vertices never came out", $time, pending_vertices.size());
            err_count++;
        end
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
